### src/assert_macros.svh
// ----------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion wrappers, clocked on clk with async reset off.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Overlapping implication: cond |-> prop
`define CHK_IMPL(label, cond, prop, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (cond) |-> (prop)) \
		else $error(msg);

// Next-cycle implication: cond |=> prop
`define CHK_NEXT(label, cond, prop, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (cond) |=> (prop)) \
		else $error(msg);

`endif

### src/tbsedf_pkg.sv
// ----------------------------------------------------------------------------
// tbsedf_pkg
// Types, constants and codes of the EDF job scheduler with bandwidth server.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package tbsedf_pkg;

	localparam int QUEUE_DEPTH = 16;
	localparam int TIME_BITS   = 32;
	localparam int IDX_BITS    = $clog2(QUEUE_DEPTH);
	localparam int EXEC_BITS   = 16;
	localparam int CLASS_BITS  = 8;
	localparam int ID_BITS     = 16;
	localparam int OUT_DL_BITS = 32;
	// shared unit operand width: wide enough for times and a 16x16 product
	localparam int OP_BITS     = (TIME_BITS > 2 * EXEC_BITS) ? TIME_BITS : 2 * EXEC_BITS;

	localparam logic [IDX_BITS-1:0]   LAST_IDX   = IDX_BITS'(QUEUE_DEPTH - 1);
	localparam logic [TIME_BITS-1:0]  TIME_MAX   = '1;
	localparam logic [CLASS_BITS-1:0] IDLE_CLASS = 8'h5A;  // 'Z'
	localparam logic [ID_BITS-1:0]    IDLE_IDENT = 16'hFFFF;

	// request codes
	localparam logic [1:0] REQ_PER  = 2'd0;
	localparam logic [1:0] REQ_APER = 2'd1;
	localparam logic [1:0] REQ_TICK = 2'd2;
	localparam logic [1:0] REQ_NONE = 2'd3;

	// status codes
	localparam logic [1:0] ST_ACCEPT = 2'd0;
	localparam logic [1:0] ST_FULL   = 2'd1;
	localparam logic [1:0] ST_SERVED = 2'd2;
	localparam logic [1:0] ST_IDLE   = 2'd3;

	// shared unit operations
	typedef logic [1:0] alu_op_t;
	localparam alu_op_t ALU_ADD = 2'd0;  // saturating add
	localparam alu_op_t ALU_MAX = 2'd1;
	localparam alu_op_t ALU_LT  = 2'd2;
	localparam alu_op_t ALU_MUL = 2'd3;

	typedef struct packed {
		logic [1:0]            req_type;
		logic [CLASS_BITS-1:0] task_type;
		logic [ID_BITS-1:0]    task_id;
		logic [EXEC_BITS-1:0]  exec_time;
		logic [EXEC_BITS-1:0]  period;
	} req_word_t;

	typedef struct packed {
		logic [1:0]             status;
		logic [OUT_DL_BITS-1:0] assigned_deadline;
		logic [CLASS_BITS-1:0]  served_type;
		logic [ID_BITS-1:0]     served_id;
		logic                   job_done;
	} rsp_word_t;

	typedef struct packed {
		logic [TIME_BITS-1:0]  deadline;
		logic [EXEC_BITS-1:0]  remaining;
		logic [CLASS_BITS-1:0] task_type;
		logic [ID_BITS-1:0]    task_id;
	} slot_t;

endpackage

### src/tbs_edf_job_scheduler_unit.sv
// ----------------------------------------------------------------------------
// tbs_edf_job_scheduler_unit
// EDF ready queue with total-bandwidth-server deadlines for aperiodic jobs.
// ----------------------------------------------------------------------------
// One request word is handled at a time; req_stall stays high until its
// response word is in the output register. A tick reads the slot RAM one
// entry per cycle and compares deadlines in the shared unit. A release
// first looks for the lowest free slot, one slot per cycle, then uses the
// shared unit (periodic: add; aperiodic: multiply, max, add) and then
// writes the slot. A full queue answers with a full status once no free
// slot is found. server_interval may be written only while idle;
// cfg_ready is always high.
`timescale 1ns / 1ps

module tbs_edf_job_scheduler_unit import tbsedf_pkg::*; (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 cfg_valid,
	output logic                 cfg_ready,
	input  logic [EXEC_BITS-1:0] cfg_data,
	input  logic                 req_valid,
	output logic                 req_stall,
	input  req_word_t            req,
	output logic                 rsp_valid,
	input  logic                 rsp_stall,
	output rsp_word_t            rsp
);

	localparam logic [3:0] S_IDLE  = 4'd0;
	localparam logic [3:0] S_FREE  = 4'd1;
	localparam logic [3:0] S_MUL   = 4'd2;
	localparam logic [3:0] S_MAX   = 4'd3;
	localparam logic [3:0] S_ADD   = 4'd4;
	localparam logic [3:0] S_WRITE = 4'd5;
	localparam logic [3:0] S_FULL  = 4'd6;
	localparam logic [3:0] S_SCAN  = 4'd7;
	localparam logic [3:0] S_LAST  = 4'd8;
	localparam logic [3:0] S_SERVE = 4'd9;

	logic [3:0]             state_q;
	logic [IDX_BITS-1:0]    scan_q;
	logic                   cmp_live_s1;
	logic [IDX_BITS-1:0]    cmp_idx_s1;
	logic                   best_vld_q;
	logic [IDX_BITS-1:0]    best_idx_q;
	slot_t                  best_q;
	logic [IDX_BITS-1:0]    slot_q;
	logic [OP_BITS-1:0]     prod_q;
	logic [TIME_BITS-1:0]   base_q;
	logic [TIME_BITS-1:0]   dl_q;
	logic [TIME_BITS-1:0]   cur_time_q;
	logic [TIME_BITS-1:0]   last_dl_q;
	logic [QUEUE_DEPTH-1:0] valid_q;
	logic [EXEC_BITS-1:0]   interval_q;
	req_word_t              req_q;
	logic                   rsp_valid_q;
	rsp_word_t              rsp_q;

	logic                   accept;
	logic                   out_free;
	logic                   is_per;
	logic [EXEC_BITS-1:0]   exec_eff;
	logic [EXEC_BITS-1:0]   iv_eff;
	alu_op_t                alu_op;
	logic [OP_BITS-1:0]     alu_a;
	logic [OP_BITS-1:0]     alu_b;
	logic [OP_BITS-1:0]     alu_res;
	logic                   cmp_en;
	logic                   take;
	logic                   free_hit;
	logic                   serve_go;
	logic                   write_go;
	logic                   full_go;
	logic                   out_load;
	rsp_word_t              out_next;
	logic [EXEC_BITS-1:0]   rem_dec;
	logic                   ram_we;
	logic [IDX_BITS-1:0]    ram_waddr;
	slot_t                  ram_wdata;
	logic [$bits(slot_t)-1:0] ram_rdata;
	slot_t                  rd_slot;

	assign cfg_ready = 1'b1;
	assign req_stall = (state_q != S_IDLE);
	assign accept    = req_valid && !req_stall;
	assign out_free  = !rsp_valid_q || !rsp_stall;
	assign rsp_valid = rsp_valid_q;
	assign rsp       = rsp_q;

	assign is_per   = (req_q.req_type == REQ_PER);
	assign exec_eff = (req_q.exec_time == '0) ? EXEC_BITS'(1) : req_q.exec_time;
	assign iv_eff   = (interval_q == '0) ? EXEC_BITS'(1) : interval_q;
	assign rd_slot  = slot_t'(ram_rdata);

	tbsedf_ram #(
		.WIDTH ($bits(slot_t)),
		.DEPTH (QUEUE_DEPTH)
	) u_slots (
		.clk   (clk),
		.we    (ram_we),
		.waddr (ram_waddr),
		.wdata (ram_wdata),
		.raddr (scan_q),
		.rdata (ram_rdata)
	);

	// operand steering for the shared unit
	always_comb begin
		alu_op = ALU_ADD;
		alu_a  = '0;
		alu_b  = '0;
		unique case (state_q)
			S_MUL: begin
				alu_op = ALU_MUL;
				alu_a  = OP_BITS'(exec_eff);
				alu_b  = OP_BITS'(iv_eff);
			end
			S_MAX: begin
				alu_op = ALU_MAX;
				alu_a  = OP_BITS'(cur_time_q);
				alu_b  = OP_BITS'(last_dl_q);
			end
			S_ADD: begin
				alu_op = ALU_ADD;
				alu_a  = is_per ? OP_BITS'(cur_time_q) : OP_BITS'(base_q);
				alu_b  = is_per ? OP_BITS'(req_q.period) : prod_q;
			end
			S_SCAN, S_LAST: begin
				alu_op = ALU_LT;
				alu_a  = OP_BITS'(rd_slot.deadline);
				alu_b  = OP_BITS'(best_q.deadline);
			end
			S_SERVE: begin
				alu_op = ALU_ADD;
				alu_a  = OP_BITS'(cur_time_q);
				alu_b  = OP_BITS'(1);
			end
			default: begin
				alu_op = ALU_ADD;
			end
		endcase
	end

	tbsedf_alu u_alu (
		.op  (alu_op),
		.a   (alu_a),
		.b   (alu_b),
		.res (alu_res)
	);

	// read data is registered in the RAM and so lags the address, hence the _s1 index
	assign cmp_en   = ((state_q == S_SCAN) && cmp_live_s1) || (state_q == S_LAST);
	assign take     = cmp_en && valid_q[cmp_idx_s1] && (!best_vld_q || alu_res[0]);
	assign free_hit = (state_q == S_FREE) && !valid_q[scan_q];
	assign serve_go = (state_q == S_SERVE) && out_free;
	assign write_go = (state_q == S_WRITE) && out_free;
	assign full_go  = (state_q == S_FULL) && out_free;
	assign out_load = serve_go || write_go || full_go;
	assign rem_dec  = best_q.remaining - EXEC_BITS'(best_q.remaining != '0);

	always_comb begin
		ram_we    = 1'b0;
		ram_waddr = slot_q;
		ram_wdata = '{deadline: dl_q, remaining: exec_eff,
			task_type: req_q.task_type, task_id: req_q.task_id};
		out_next  = '0;
		if (write_go) begin
			ram_we                     = 1'b1;
			out_next.status            = ST_ACCEPT;
			out_next.assigned_deadline = OUT_DL_BITS'(dl_q);
		end else if (full_go) begin
			out_next.status = ST_FULL;
		end else if (serve_go) begin
			if (best_vld_q) begin
				ram_we               = 1'b1;
				ram_waddr            = best_idx_q;
				ram_wdata            = best_q;
				ram_wdata.remaining  = rem_dec;
				out_next.status      = ST_SERVED;
				out_next.served_type = best_q.task_type;
				out_next.served_id   = best_q.task_id;
				out_next.job_done    = (rem_dec == '0);
			end else begin
				out_next.status      = ST_IDLE;
				out_next.served_type = IDLE_CLASS;
				out_next.served_id   = IDLE_IDENT;
			end
		end
	end

	// control state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			scan_q      <= '0;
			cmp_live_s1 <= 1'b0;
			best_vld_q  <= 1'b0;
			cur_time_q  <= '0;
			last_dl_q   <= '0;
			valid_q     <= '0;
			interval_q  <= EXEC_BITS'(1);
			rsp_valid_q <= 1'b0;
		end else begin
			if (cfg_valid && cfg_ready) begin
				interval_q <= cfg_data;
			end

			if (out_load) begin
				rsp_valid_q <= 1'b1;
			end else if (!rsp_stall) begin
				rsp_valid_q <= 1'b0;
			end

			if (take) begin
				best_vld_q <= 1'b1;
			end

			unique case (state_q)
				S_IDLE: begin
					if (accept) begin
						scan_q      <= '0;
						cmp_live_s1 <= 1'b0;
						best_vld_q  <= 1'b0;
						unique case (req.req_type) inside
							REQ_PER, REQ_APER: state_q <= S_FREE;
							REQ_TICK:          state_q <= S_SCAN;
							default:           state_q <= S_IDLE;
						endcase
					end
				end
				S_FREE: begin
					if (!valid_q[scan_q]) begin
						state_q <= is_per ? S_ADD : S_MUL;
					end else if (scan_q == LAST_IDX) begin
						state_q <= S_FULL;
					end else begin
						scan_q <= scan_q + IDX_BITS'(1);
					end
				end
				S_MUL: state_q <= S_MAX;
				S_MAX: state_q <= S_ADD;
				S_ADD: state_q <= S_WRITE;
				S_WRITE: begin
					if (write_go) begin
						valid_q[slot_q] <= 1'b1;
						if (!is_per) begin
							last_dl_q <= dl_q;
						end
						state_q <= S_IDLE;
					end
				end
				S_FULL: begin
					if (full_go) begin
						state_q <= S_IDLE;
					end
				end
				S_SCAN: begin
					cmp_live_s1 <= 1'b1;
					if (scan_q == LAST_IDX) begin
						state_q <= S_LAST;
					end else begin
						scan_q <= scan_q + IDX_BITS'(1);
					end
				end
				S_LAST: state_q <= S_SERVE;
				S_SERVE: begin
					if (serve_go) begin
						if (best_vld_q && (rem_dec == '0)) begin
							valid_q[best_idx_q] <= 1'b0;
						end
						cur_time_q <= alu_res[TIME_BITS-1:0];
						state_q    <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	// datapath registers
	always_ff @(posedge clk) begin
		if (accept) begin
			req_q <= req;
		end
		if (out_load) begin
			rsp_q <= out_next;
		end
		if (free_hit) begin
			slot_q <= scan_q;
		end
		if (state_q == S_MUL) begin
			prod_q <= alu_res;
		end
		if (state_q == S_MAX) begin
			base_q <= alu_res[TIME_BITS-1:0];
		end
		if (state_q == S_ADD) begin
			dl_q <= alu_res[TIME_BITS-1:0];
		end
		cmp_idx_s1 <= scan_q;
		if (take) begin
			best_q     <= rd_slot;
			best_idx_q <= cmp_idx_s1;
		end
	end

endmodule

### src/tbsedf_ram.sv
// ----------------------------------------------------------------------------
// tbsedf_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tbsedf_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata_q <= mem_q[raddr];
	end

	assign rdata = rdata_q;

endmodule

### src/tbsedf_alu.sv
// ----------------------------------------------------------------------------
// tbsedf_alu
// Shared arithmetic unit: saturating time add, max, less-than, 16x16 multiply.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tbsedf_alu import tbsedf_pkg::*; (
	input  alu_op_t              op,
	input  logic [OP_BITS-1:0]   a,
	input  logic [OP_BITS-1:0]   b,
	output logic [OP_BITS-1:0]   res
);

	logic [OP_BITS:0]       sum;
	logic [2*EXEC_BITS-1:0] prod;
	logic                   lt;

	assign sum  = {1'b0, a} + {1'b0, b};
	assign prod = a[EXEC_BITS-1:0] * b[EXEC_BITS-1:0];
	assign lt   = (a < b);

	always_comb begin
		unique case (op)
			ALU_ADD: begin
				if (sum > (OP_BITS + 1)'(TIME_MAX)) begin
					res = OP_BITS'(TIME_MAX);
				end else begin
					res = sum[OP_BITS-1:0];
				end
			end
			ALU_MAX: res = lt ? b : a;
			ALU_LT:  res = OP_BITS'(lt);
			ALU_MUL: res = OP_BITS'(prod);
			default: res = '0;
		endcase
	end

endmodule

### src/tbsedf_checker.sv
// ----------------------------------------------------------------------------
// tbsedf_checker
// Port-level checks of the scheduler handshakes, bound to the top level.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "assert_macros.svh"

module tbsedf_checker import tbsedf_pkg::*; (
	input logic      clk,
	input logic      arst_n,
	input logic      req_valid,
	input logic      req_stall,
	input req_word_t req,
	input logic      rsp_valid,
	input logic      rsp_stall,
	input rsp_word_t rsp
);

	// a held response word must not change
	`CHK_NEXT(a_rsp_hold, rsp_valid && rsp_stall, rsp_valid && $stable(rsp), "rsp word changed while stalled")

	// a real request keeps the block busy on the following cycle
	`CHK_NEXT(a_busy_after_req, req_valid && !req_stall && (req.req_type != REQ_NONE), req_stall, "no busy after accepted request")

	// a new response word only shows once the block is free again
	`CHK_IMPL(a_rsp_when_free, $rose(rsp_valid), !req_stall, "response shown while still busy")

	// an idle tick reports the idle marker
	`CHK_IMPL(a_idle_word, rsp_valid && (rsp.status == ST_IDLE), (rsp.served_id == IDLE_IDENT) && (rsp.served_type == IDLE_CLASS) && !rsp.job_done, "bad idle word")

endmodule

bind tbs_edf_job_scheduler_unit tbsedf_checker u_tbsedf_checker (.*);

### tb/tb_tbs_edf_job_scheduler_unit.sv
// ----------------------------------------------------------------------------
// tb_tbs_edf_job_scheduler_unit
// Checks the EDF job scheduler with bandwidth-server deadlines against a
// cycle-free predictor: a directed table first, then random request phases
// under several server intervals, then a closing phase that pushes the
// server deadline into saturation.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb_tbs_edf_job_scheduler_unit;
	import tbsedf_pkg::*;

	localparam int SETTLE      = 2 * QUEUE_DEPTH + 16;
	localparam int CYCLE_LIMIT = 500000;
	localparam int PRESS_LEN   = 300;
	localparam int PHASES      = 7;
	localparam int PHASE_WORDS = 100;

	typedef struct {
		bit               set_si;
		logic [EXEC_BITS-1:0] si;
		req_word_t        w;
		bit               fixed;
		rsp_word_t        want;
	} plan_row_t;

	logic      clk = 1'b0;
	logic      arst_n;
	logic      cfg_valid;
	logic      cfg_ready;
	logic [EXEC_BITS-1:0] cfg_data;
	logic      req_valid;
	logic      req_stall;
	req_word_t req;
	logic      rsp_valid;
	logic      rsp_stall;
	rsp_word_t rsp;

	// predictor state
	logic [TIME_BITS-1:0]  sched_now;
	logic [TIME_BITS-1:0]  tbs_last_dl;
	logic [EXEC_BITS-1:0]  srv_interval;
	bit                    q_busy  [QUEUE_DEPTH];
	logic [TIME_BITS-1:0]  q_dl    [QUEUE_DEPTH];
	logic [EXEC_BITS-1:0]  q_left  [QUEUE_DEPTH];
	logic [CLASS_BITS-1:0] q_class [QUEUE_DEPTH];
	logic [ID_BITS-1:0]    q_ident [QUEUE_DEPTH];

	rsp_word_t outcome_q [$];
	plan_row_t plan [$];
	int        errs = 0;
	int        cyc = 0;
	int        next_gap = 0;
	bit        snd_burst = 1'b0;
	bit        press_go = 1'b0;
	logic      press_hold = 1'b0;

	tbs_edf_job_scheduler_unit u_top (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_data  (cfg_data),
		.req_valid (req_valid),
		.req_stall (req_stall),
		.req       (req),
		.rsp_valid (rsp_valid),
		.rsp_stall (rsp_stall),
		.rsp       (rsp)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	always @(posedge clk) begin
		cyc <= cyc + 1;
		if (cyc >= CYCLE_LIMIT) begin
			$display("tb_tbs_edf_job_scheduler_unit: done, errors");
			$finish;
		end
	end

	function automatic req_word_t mk_req(logic [1:0] t, logic [CLASS_BITS-1:0] c,
			logic [ID_BITS-1:0] id, logic [EXEC_BITS-1:0] ex, logic [EXEC_BITS-1:0] per);
		req_word_t w;
		w.req_type  = t;
		w.task_type = c;
		w.task_id   = id;
		w.exec_time = ex;
		w.period    = per;
		return w;
	endfunction

	function automatic rsp_word_t mk_rsp(logic [1:0] st, logic [OUT_DL_BITS-1:0] dl,
			logic [CLASS_BITS-1:0] c, logic [ID_BITS-1:0] id, logic done);
		rsp_word_t r;
		r.status            = st;
		r.assigned_deadline = dl;
		r.served_type       = c;
		r.served_id         = id;
		r.job_done          = done;
		return r;
	endfunction

	// appends one row to the directed table
	function automatic void add_row(bit set_si, logic [EXEC_BITS-1:0] si, req_word_t w,
			bit fixed, rsp_word_t want);
		plan_row_t row;
		row.set_si = set_si;
		row.si     = si;
		row.w      = w;
		row.fixed  = fixed;
		row.want   = want;
		plan = {plan, row};
	endfunction

	function automatic logic [TIME_BITS-1:0] sat_sum(logic [TIME_BITS-1:0] a, logic [63:0] b);
		logic [64:0] s;
		s = 65'(a) + 65'(b);
		return (s > 65'(TIME_MAX)) ? TIME_MAX : s[TIME_BITS-1:0];
	endfunction

	// Advances the scheduler state by one request word; returns 0 when the
	// word produces no response.
	function automatic bit edf_outcome(input req_word_t w, output rsp_word_t r);
		int                   best;
		int                   slot;
		logic [EXEC_BITS-1:0] units;
		logic [EXEC_BITS-1:0] iv;
		logic [TIME_BITS-1:0] base;
		logic [TIME_BITS-1:0] dl;
		r = '0;
		if (w.req_type == REQ_NONE)
			return 1'b0;
		if (w.req_type == REQ_TICK) begin
			best = -1;
			for (int i = 0; i < QUEUE_DEPTH; i++)
				if (q_busy[i] && (best < 0 || q_dl[i] < q_dl[best]))
					best = i;
			if (best < 0) begin
				r.status      = ST_IDLE;
				r.served_type = IDLE_CLASS;
				r.served_id   = IDLE_IDENT;
			end else begin
				r.status      = ST_SERVED;
				r.served_type = q_class[best];
				r.served_id   = q_ident[best];
				if (q_left[best] != 0)
					q_left[best] = q_left[best] - EXEC_BITS'(1);
				if (q_left[best] == 0) begin
					q_busy[best] = 1'b0;
					r.job_done   = 1'b1;
				end
			end
			sched_now = sat_sum(sched_now, 64'd1);
			return 1'b1;
		end
		units = (w.exec_time == 0) ? EXEC_BITS'(1) : w.exec_time;
		slot = -1;
		for (int i = QUEUE_DEPTH - 1; i >= 0; i--)
			if (!q_busy[i])
				slot = i;
		if (slot < 0) begin
			r.status = ST_FULL;
			return 1'b1;
		end
		if (w.req_type == REQ_PER) begin
			dl = sat_sum(sched_now, 64'(w.period));
		end else begin
			iv   = (srv_interval == 0) ? EXEC_BITS'(1) : srv_interval;
			base = (sched_now > tbs_last_dl) ? sched_now : tbs_last_dl;
			dl   = sat_sum(base, 64'(units) * 64'(iv));
			tbs_last_dl = dl;
		end
		q_busy[slot]  = 1'b1;
		q_dl[slot]    = dl;
		q_left[slot]  = units;
		q_class[slot] = w.task_type;
		q_ident[slot] = w.task_id;
		r.status            = ST_ACCEPT;
		r.assigned_deadline = OUT_DL_BITS'(dl);
		return 1'b1;
	endfunction

	function automatic req_word_t draw_job(int tick_pct);
		req_word_t w;
		int        r;
		r = $urandom_range(0, 99);
		w.task_type = CLASS_BITS'($urandom);
		w.task_id   = ID_BITS'($urandom);
		w.period    = ($urandom_range(0, 2) == 0) ? EXEC_BITS'($urandom_range(0, 20))
			: EXEC_BITS'($urandom);
		w.exec_time = ($urandom_range(0, 99) == 0) ? EXEC_BITS'($urandom)
			: EXEC_BITS'($urandom_range(0, 8));
		if (r < 5)
			w.req_type = REQ_NONE;
		else if (r < 5 + tick_pct)
			w.req_type = REQ_TICK;
		else if (r[0])
			w.req_type = REQ_PER;
		else
			w.req_type = REQ_APER;
		// keep the server deadline clear of saturation until the closing phase
		if (w.req_type == REQ_APER && srv_interval > 256)
			w.exec_time = EXEC_BITS'($urandom_range(0, 8));
		return w;
	endfunction

	// Offers one request word; the valid is lowered in the step of acceptance
	// when a gap or a pause follows.
	task automatic send_word(input req_word_t w, input bit fixed, input rsp_word_t want,
			input bit tail);
		rsp_word_t r;
		bit        got;
		if (next_gap != 0)
			repeat (next_gap) @(posedge clk);
		req_valid <= 1'b1;
		req       <= w;
		do @(posedge clk); while (req_stall);
		got = edf_outcome(w, r);
		if (got)
			outcome_q = {outcome_q, fixed ? want : r};
		next_gap = snd_burst ? 0 : $urandom_range(0, 12);
		if (next_gap != 0 || tail)
			req_valid <= 1'b0;
	endtask

	task automatic write_interval(input logic [EXEC_BITS-1:0] v);
		while (outcome_q.size() != 0) @(posedge clk);
		repeat (SETTLE) @(posedge clk);
		cfg_valid <= 1'b1;
		cfg_data  <= v;
		do @(posedge clk); while (!cfg_ready);
		cfg_valid <= 1'b0;
		srv_interval = v;
	endtask

	// long receiver hold-off so the block backs up into its input
	initial begin
		wait (press_go);
		@(posedge clk);
		press_hold <= 1'b1;
		repeat (PRESS_LEN) @(posedge clk);
		press_hold <= 1'b0;
	end

	initial begin
		int        gap;
		int        words;
		bit        burst;
		rsp_word_t e;
		rsp_stall = 1'b0;
		words = 0;
		burst = 1'b0;
		wait (arst_n === 1'b1);
		forever begin
			if (words % 40 == 0)
				burst = ($urandom_range(0, 2) == 0);
			gap = burst ? 0 : $urandom_range(0, 12);
			if (gap != 0 || press_hold) begin
				rsp_stall <= 1'b1;
				repeat (gap) @(posedge clk);
				while (press_hold) @(posedge clk);
			end
			rsp_stall <= 1'b0;
			do @(posedge clk); while (!rsp_valid);
			words++;
			if (outcome_q.size() == 0) begin
				$display("%0t: response word with nothing outstanding: st=%0d dl=%h type=%h id=%h done=%b",
					$time, rsp.status, rsp.assigned_deadline, rsp.served_type,
					rsp.served_id, rsp.job_done);
				errs++;
			end else begin
				e = outcome_q.pop_front();
				if (rsp.status !== e.status || rsp.assigned_deadline !== e.assigned_deadline
						|| rsp.served_type !== e.served_type || rsp.served_id !== e.served_id
						|| rsp.job_done !== e.job_done) begin
					$display("%0t: word mismatch: expected st=%0d dl=%h type=%h id=%h done=%b, got st=%0d dl=%h type=%h id=%h done=%b",
						$time, e.status, e.assigned_deadline, e.served_type, e.served_id,
						e.job_done, rsp.status, rsp.assigned_deadline, rsp.served_type,
						rsp.served_id, rsp.job_done);
					errs++;
				end
			end
		end
	end

	initial begin
		req_word_t w;
		int        n;
		int        pct;
		int        free_cnt;
		int        tries;
		bit        tail;
		arst_n    = 1'b0;
		cfg_valid = 1'b0;
		cfg_data  = '0;
		req_valid = 1'b0;
		req       = '0;
		sched_now    = '0;
		tbs_last_dl  = '0;
		srv_interval = EXEC_BITS'(1);
		for (int i = 0; i < QUEUE_DEPTH; i++) begin
			q_busy[i]  = 1'b0;
			q_dl[i]    = '0;
			q_left[i]  = '0;
			q_class[i] = '0;
			q_ident[i] = '0;
		end

		// directed table; server interval starts at one
		add_row(1'b0, '0, mk_req(REQ_TICK, 8'h00, 16'h0000, 16'h0000, 16'h0000),
			1'b1, mk_rsp(ST_IDLE, 32'h0, IDLE_CLASS, IDLE_IDENT, 1'b0));
		add_row(1'b0, '0, mk_req(REQ_NONE, 8'hFF, 16'hFFFF, 16'hFFFF, 16'hFFFF),
			1'b0, '0);
		// zero period and zero exec: deadline is now
		add_row(1'b0, '0, mk_req(REQ_PER, 8'h00, 16'h0000, 16'h0000, 16'h0000),
			1'b1, mk_rsp(ST_ACCEPT, 32'd1, 8'h00, 16'h0000, 1'b0));
		add_row(1'b0, '0, mk_req(REQ_PER, 8'hFF, 16'hFFFF, 16'hFFFF, 16'hFFFF),
			1'b1, mk_rsp(ST_ACCEPT, 32'h0001_0000, 8'h00, 16'h0000, 1'b0));
		add_row(1'b0, '0, mk_req(REQ_APER, 8'h41, 16'h1234, 16'h0000, 16'h0000),
			1'b1, mk_rsp(ST_ACCEPT, 32'd2, 8'h00, 16'h0000, 1'b0));
		add_row(1'b0, '0, mk_req(REQ_APER, 8'h42, 16'h0042, 16'h0003, 16'h0000),
			1'b1, mk_rsp(ST_ACCEPT, 32'd5, 8'h00, 16'h0000, 1'b0));
		add_row(1'b0, '0, mk_req(REQ_TICK, 8'h00, 16'h0000, 16'h0000, 16'h0000),
			1'b1, mk_rsp(ST_SERVED, 32'h0, 8'h00, 16'h0000, 1'b1));
		add_row(1'b0, '0, mk_req(REQ_PER, 8'h11, 16'h0011, 16'h0002, 16'h0003),
			1'b1, mk_rsp(ST_ACCEPT, 32'd5, 8'h00, 16'h0000, 1'b0));
		add_row(1'b0, '0, mk_req(REQ_TICK, 8'h00, 16'h0000, 16'h0000, 16'h0000),
			1'b1, mk_rsp(ST_SERVED, 32'h0, 8'h41, 16'h1234, 1'b1));
		// equal deadlines: lowest slot wins
		add_row(1'b0, '0, mk_req(REQ_TICK, 8'h00, 16'h0000, 16'h0000, 16'h0000),
			1'b1, mk_rsp(ST_SERVED, 32'h0, 8'h11, 16'h0011, 1'b0));
		add_row(1'b0, '0, mk_req(REQ_TICK, 8'h00, 16'h0000, 16'h0000, 16'h0000),
			1'b1, mk_rsp(ST_SERVED, 32'h0, 8'h11, 16'h0011, 1'b1));
		// zero interval behaves as one
		add_row(1'b1, 16'h0000, '0, 1'b0, '0);
		add_row(1'b0, '0, mk_req(REQ_APER, 8'h80, 16'h8000, 16'h0002, 16'h0000),
			1'b1, mk_rsp(ST_ACCEPT, 32'd7, 8'h00, 16'h0000, 1'b0));
		add_row(1'b1, 16'h0003, '0, 1'b0, '0);
		add_row(1'b0, '0, mk_req(REQ_APER, 8'h01, 16'h0001, 16'h0002, 16'h0000),
			1'b1, mk_rsp(ST_ACCEPT, 32'd13, 8'h00, 16'h0000, 1'b0));
		for (int i = 0; i < QUEUE_DEPTH - 4; i++)
			add_row(1'b0, '0, mk_req(REQ_PER, CLASS_BITS'(8'h60 + i),
				ID_BITS'(16'h0100 + i), 16'h0001, EXEC_BITS'((i % 4) * 2)), 1'b0, '0);
		// full queue rejects both kinds of release
		add_row(1'b0, '0, mk_req(REQ_PER, 8'h77, 16'h7777, 16'h0001, 16'h0001),
			1'b1, mk_rsp(ST_FULL, 32'h0, 8'h00, 16'h0000, 1'b0));
		add_row(1'b0, '0, mk_req(REQ_APER, 8'h78, 16'h7878, 16'h0004, 16'h0000),
			1'b1, mk_rsp(ST_FULL, 32'h0, 8'h00, 16'h0000, 1'b0));
		add_row(1'b0, '0, mk_req(REQ_TICK, 8'h00, 16'h0000, 16'h0000, 16'h0000),
			1'b0, '0);
		add_row(1'b0, '0, mk_req(REQ_APER, 8'h79, 16'h7979, 16'h0001, 16'h0000),
			1'b0, '0);

		repeat (9) @(posedge clk);
		arst_n <= 1'b1;

		for (int i = 0; i < plan.size(); i++) begin
			if (plan[i].set_si) begin
				write_interval(plan[i].si);
			end else begin
				tail = (i == plan.size() - 1) || plan[i + 1].set_si;
				send_word(plan[i].w, plan[i].fixed, plan[i].want, tail);
			end
		end

		// random phases, one server interval each
		pct = 50;
		for (int p = 0; p < PHASES; p++) begin
			if (p == 1)
				write_interval(16'hFFFF);
			else if (p == 2)
				write_interval(16'h0000);
			else if (p > 2) begin
				case ($urandom_range(0, 3))
					0: write_interval(EXEC_BITS'(1));
					1: write_interval(EXEC_BITS'($urandom_range(2, 16)));
					2: write_interval(EXEC_BITS'($urandom_range(17, 1000)));
					default: write_interval(EXEC_BITS'($urandom));
				endcase
			end
			if (p == 3)
				press_go = 1'b1;
			n = 0;
			while (n < PHASE_WORDS) begin
				if (n % 25 == 0) begin
					case ($urandom_range(0, 2))
						0: pct = 20;
						1: pct = 50;
						default: pct = 80;
					endcase
					snd_burst = ($urandom_range(0, 3) == 0);
				end
				w = draw_job(pct);
				tail = (w.req_type != REQ_NONE) && (n == PHASE_WORDS - 1);
				send_word(w, 1'b0, '0, tail);
				if (w.req_type != REQ_NONE)
					n++;
			end
		end

		// closing phase: widest interval and longest jobs saturate the server deadline
		snd_burst = 1'b0;
		write_interval(16'hFFFF);
		tries = 0;
		forever begin
			free_cnt = 0;
			for (int i = 0; i < QUEUE_DEPTH; i++)
				if (!q_busy[i])
					free_cnt++;
			if (free_cnt >= 2 || tries >= 300)
				break;
			send_word(mk_req(REQ_TICK, 8'h00, 16'h0000, 16'h0000, 16'h0000), 1'b0, '0, 1'b0);
			tries++;
		end
		send_word(mk_req(REQ_APER, 8'hA5, 16'h5AA5, 16'hFFFF, 16'h0000), 1'b0, '0, 1'b0);
		send_word(mk_req(REQ_APER, 8'h5A, 16'hA55A, 16'hFFFF, 16'hFFFF), 1'b0, '0, 1'b0);
		send_word(mk_req(REQ_PER, 8'h3C, 16'h00C3, 16'h0001, 16'hFFFF), 1'b0, '0, 1'b0);
		send_word(mk_req(REQ_TICK, 8'h00, 16'h0000, 16'h0000, 16'h0000), 1'b0, '0, 1'b1);

		while (outcome_q.size() != 0) @(posedge clk);
		repeat (SETTLE) @(posedge clk);
		if (errs == 0)
			$display("tb_tbs_edf_job_scheduler_unit: done, clean");
		else
			$display("tb_tbs_edf_job_scheduler_unit: done, errors");
		$finish;
	end

endmodule
